// ===== rtl/core/adn_pkg.sv =====
// Package for the ADPCM nibble decoder: queue entry type, back-end states,
// sample and step limits and the step adaptation table.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package adn_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned HDR_BYTES   = 4;

    // Smallest step that a code may leave behind.
    localparam logic signed [15:0] STEP_FLOOR = 16'sd16;
    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

    // Header byte positions within the packet.
    localparam logic [1:0] HDR_PRED_LO = 2'd0;
    localparam logic [1:0] HDR_PRED_HI = 2'd1;
    localparam logic [1:0] HDR_STEP_LO = 2'd2;
    localparam logic [1:0] HDR_STEP_HI = 2'd3;

    // One classified byte as it travels from the front end to the back end.
    typedef struct packed {
        logic       is_data;
        logic [1:0] hdr_idx;
        logic [7:0] data;
        logic       last;
    } qentry_t;

    // Push side of the queue as seen from the front end.
    typedef struct packed {
        logic    valid;
        qentry_t entry;
    } qpush_t;

    // Back end sequencer: IDLE takes a beat from the queue and forms the
    // products of the low nibble; the high nibble follows in MUL1.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_UPD0,
        BK_MUL1,
        BK_UPD1
    } bk_state_t;

    function automatic logic [9:0] adapt_gain(input logic [2:0] mag);
        logic [9:0] gain;
        unique case (mag)
            3'd4:    gain = 10'd307;
            3'd5:    gain = 10'd409;
            3'd6:    gain = 10'd512;
            3'd7:    gain = 10'd614;
            default: gain = 10'd230;
        endcase
        return gain;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/adn_queue.sv =====
// Two-entry queue of classified bytes between the decoder front and back ends.
// Depends on adn_pkg for the entry and push types.
`timescale 1ns / 1ps
`default_nettype none

module adn_queue
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire adn_pkg::qpush_t push,
    output logic                 full,
    input  wire logic            pop,
    output logic                 head_valid,
    output adn_pkg::qentry_t     head
);
    import adn_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    qentry_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    assign do_push = push.valid && !full;
    assign do_pop  = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/adn_front.sv =====
// Front end of the ADPCM nibble decoder: accepts input beats, tracks the header
// position and tags each byte as header or data. Depends on adn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adn_front
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire logic [7:0]      packet_byte,
    input  wire logic            first_of_packet,
    input  wire logic            last_of_packet,
    input  wire logic            queue_full,
    output adn_pkg::qpush_t      push
);
    import adn_pkg::*;

    logic [2:0] hdr_cnt_reg, hdr_cnt_next;
    logic [2:0] hdr_cnt_eff;
    logic       in_header;
    logic       accept;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    // A first flag restarts the header with this very byte.
    assign hdr_cnt_eff = first_of_packet ? 3'd0 : hdr_cnt_reg;
    assign in_header   = (hdr_cnt_eff < 3'(HDR_BYTES));

    always_comb
    begin
        push.valid         = accept;
        push.entry.is_data = !in_header;
        push.entry.hdr_idx = hdr_cnt_eff[1:0];
        push.entry.data    = packet_byte;
        push.entry.last    = last_of_packet;

        hdr_cnt_next = hdr_cnt_reg;
        if (accept)
        begin
            if (last_of_packet)
            begin
                hdr_cnt_next = 3'd0;
            end
            else if (in_header)
            begin
                hdr_cnt_next = hdr_cnt_eff + 3'd1;
            end
            else
            begin
                hdr_cnt_next = hdr_cnt_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_cnt_reg <= '0;
        end
        else
        begin
            hdr_cnt_reg <= hdr_cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/adn_back.sv =====
// Back end of the ADPCM nibble decoder: applies header bytes, decodes the two
// nibbles of each data byte and holds the result register. Depends on adn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adn_back
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             head_valid,
    input  wire adn_pkg::qentry_t head,
    output logic                  pop,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic signed [15:0]    sample_first,
    output logic signed [15:0]    sample_second,
    output logic                  end_of_packet
);
    import adn_pkg::*;

    bk_state_t state_reg, state_next;

    logic signed [15:0] pred_reg;
    logic signed [15:0] step_reg;
    logic [7:0]         byte_reg;
    logic               last_reg;
    logic signed [15:0] sample0_reg;
    logic signed [19:0] delta_reg;
    logic signed [26:0] gprod_reg;
    logic               neg_reg;
    logic               out_valid_reg;
    logic signed [15:0] out_first_reg;
    logic signed [15:0] out_second_reg;
    logic               out_last_reg;

    logic               out_free;
    logic               take_head;
    logic               do_mul;
    logic               do_upd;
    logic               out_load;
    logic [3:0]         code;
    logic signed [20:0] sum;
    logic signed [15:0] pred_new;
    logic signed [15:0] step_raw;
    logic signed [15:0] step_new;

    assign out_free = !out_valid_reg || !out_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (head_valid && head.is_data)
                begin
                    state_next = BK_UPD0;
                end
            end
            BK_UPD0: state_next = BK_MUL1;
            BK_MUL1: state_next = BK_UPD1;
            BK_UPD1:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        take_head = 1'b0;
        do_mul    = 1'b0;
        do_upd    = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                take_head = head_valid;
                do_mul    = head_valid && head.is_data;
            end
            BK_UPD0: do_upd = 1'b1;
            BK_MUL1: do_mul = 1'b1;
            BK_UPD1:
            begin
                do_upd   = out_free;
                out_load = out_free;
            end
            default:
            begin
                take_head = 1'b0;
            end
        endcase
    end

    assign pop  = take_head;
    assign code = (state_reg == BK_IDLE) ? head.data[3:0] : byte_reg[7:4];

    // Sample update with saturation, step adaptation with floor.
    always_comb
    begin
        sum = neg_reg ? (21'(pred_reg) - 21'(delta_reg)) : (21'(pred_reg) + 21'(delta_reg));
        if (sum[20:15] == 6'b000000 || sum[20:15] == 6'b111111)
        begin
            pred_new = sum[15:0];
        end
        else
        begin
            pred_new = sum[20] ? SAMPLE_MIN : SAMPLE_MAX;
        end
        step_raw = gprod_reg[23:8];
        step_new = (step_raw < STEP_FLOOR) ? STEP_FLOOR : step_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            pred_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (take_head && !head.is_data)
            begin
                unique case (head.hdr_idx)
                    HDR_PRED_LO: pred_reg[7:0]  <= head.data;
                    HDR_PRED_HI: pred_reg[15:8] <= head.data;
                    HDR_STEP_LO: step_reg[7:0]  <= head.data;
                    HDR_STEP_HI: step_reg[15:8] <= head.data;
                    default:     pred_reg       <= pred_reg;
                endcase
            end
            else if (do_upd)
            begin
                pred_reg <= pred_new;
                step_reg <= step_new;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_head && head.is_data)
        begin
            byte_reg <= head.data;
            last_reg <= head.last;
        end
        if (do_mul)
        begin
            neg_reg   <= code[3];
            delta_reg <= $signed({1'b0, code[2:0]}) * step_reg;
            gprod_reg <= $signed({1'b0, adapt_gain(code[2:0])}) * step_reg;
        end
        if (state_reg == BK_UPD0)
        begin
            sample0_reg <= pred_new;
        end
        if (out_load)
        begin
            out_first_reg  <= sample0_reg;
            out_second_reg <= pred_new;
            out_last_reg   <= last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample_first  = out_first_reg;
    assign sample_second = out_second_reg;
    assign end_of_packet = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/adpcm_nibble_decoder.sv =====
// Top level of the 4-bit ADPCM nibble decoder.
// Depends on adn_pkg, adn_front, adn_queue and adn_back.
//
// Usage:
// The input channel carries one packet byte per beat with its first and last
// flags (in_valid / in_stall). A packet opens with a four-byte header: the start
// sample, then the step size, both little-endian. Each later byte holds two codes,
// low nibble first, and yields one output beat with both decoded samples and the
// end-of-packet flag (out_valid / out_stall). Header bytes yield no output beat.
// The front end tags every accepted byte as header or data and passes it through
// a two-entry queue to the back end, so input can be taken while the back end is
// busy or waits on the receiver.
// Sequencing: the back end handles a data byte in four steps, two per nibble: one
// to form the two products of the shared multiply stage and one to update the
// sample and the step. The two nibbles depend on each other, so that chain sets
// the rate; the next byte waits for the last step, which waits while the output
// register is held. A header byte is applied as it is taken. A data byte accepted
// into an empty block passes the queue, then the IDLE, UPD0, MUL1 and UPD1 states,
// to the output register. Reset clears the header position, the sample and the
// step to zero and empties the queue and the output register. When the receiver
// stalls, the result stays in the output register, the back end takes at most one
// more data byte up to its last step, and the input stalls once the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module adpcm_nibble_decoder
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    packet_byte,
    input  wire logic          first_of_packet,
    input  wire logic          last_of_packet,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic signed [15:0] sample_first,
    output logic signed [15:0] sample_second,
    output logic               end_of_packet
);
    import adn_pkg::*;

    qpush_t  push;
    logic    queue_full;
    logic    pop;
    logic    head_valid;
    qentry_t head;

    // Classifies input beats and keeps the header position.
    adn_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .packet_byte     (packet_byte),
        .first_of_packet (first_of_packet),
        .last_of_packet  (last_of_packet),
        .queue_full      (queue_full),
        .push            (push)
    );

    // Decouples the front end from the decode sequencer.
    adn_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Owns the predictor state and the output register.
    adn_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample_first  (sample_first),
        .sample_second (sample_second),
        .end_of_packet (end_of_packet)
    );

endmodule

`default_nettype wire

// ===== bench/tb_adpcm_nibble_decoder.sv =====
// Self-checking testbench for adpcm_nibble_decoder: directed packets, then random packets.
// Uses a built-in predictor of the decoder and random idling on both channels.
// Depends on adn_pkg and the adpcm_nibble_decoder RTL.
`timescale 1ns / 1ps

module tb_adpcm_nibble_decoder;

    import adn_pkg::*;

    localparam int TARGET_BEATS   = 2000;
    localparam int WATCHDOG_LIMIT = 2000;
    // The drain wait after the last owed pair catches stray output beats.
    localparam int DRAIN_CYCLES   = 16;
    localparam int IDLE_PERCENT   = 23;
    localparam int NUM_DIRECTED   = 25;

    // One decoded pair as it leaves the block.
    typedef struct packed {
        logic signed [15:0] lo_sample;
        logic signed [15:0] hi_sample;
        logic               eop;
    } pair_t;

    localparam pair_t NO_PAIR = '0;

    // One row of the directed table. When want_typed is set, the pair in the row
    // is the expected result, read straight off the arithmetic. Otherwise the
    // predictor supplies the expected result.
    typedef struct {
        logic [7:0] data;
        logic       first;
        logic       last;
        bit         want_typed;
        pair_t      want;
    } stim_row_t;

    // Step adaptation gains, indexed by code magnitude.
    localparam int STEP_GAIN [8] = '{230, 230, 230, 230, 307, 409, 512, 614};

    // Clock, reset and the block's ports. Every input is known from time zero.
    logic               clk             = 1'b0;
    logic               rst_n           = 1'b0;
    logic               in_valid        = 1'b0;
    logic               in_stall;
    logic [7:0]         packet_byte     = 8'h00;
    logic               first_of_packet = 1'b0;
    logic               last_of_packet  = 1'b0;
    logic               out_valid;
    logic               out_stall       = 1'b0;
    logic signed [15:0] sample_first;
    logic signed [15:0] sample_second;
    logic               end_of_packet;

    // Predictor state: header position, running sample and running step.
    int                 hdr_pos;
    logic signed [15:0] model_sample;
    logic signed [15:0] model_step;

    // Pairs that the block still owes, oldest first.
    pair_t              owed_pairs [$];
    pair_t              head_pair;

    // While quiet is set, neither side idles.
    bit                 quiet = 1'b0;
    int                 errors = 0;
    int                 beats_sent = 0;
    int                 pairs_checked = 0;
    int                 packets_sent = 0;
    int                 idle_cycles = 0;

    adpcm_nibble_decoder dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .packet_byte     (packet_byte),
        .first_of_packet (first_of_packet),
        .last_of_packet  (last_of_packet),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .sample_first    (sample_first),
        .sample_second   (sample_second),
        .end_of_packet   (end_of_packet)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Directed table. The first packet arrives after reset without a first flag.
    // The second packet drives the start sample and the step to their upper
    // extremes, so that both samples saturate high and then low. The third packet
    // has the most negative step in its header; the step is used as given once
    // and then falls to the floor. The fourth packet ends inside its header, so
    // the next bytes start a new header with no first flag. That header carries
    // a step below the floor. The last row sets the first and last flags on the
    // same byte.
    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{8'h34, 1'b0, 1'b0, 1'b0, NO_PAIR},
        '{8'h12, 1'b0, 1'b0, 1'b0, NO_PAIR},
        '{8'h20, 1'b0, 1'b0, 1'b0, NO_PAIR},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_PAIR},
        '{8'h00, 1'b0, 1'b0, 1'b1, '{16'sd4660, 16'sd4660, 1'b0}},
        '{8'h89, 1'b0, 1'b1, 1'b0, NO_PAIR},
        '{8'hFF, 1'b1, 1'b0, 1'b0, NO_PAIR},
        '{8'h7F, 1'b0, 1'b0, 1'b0, NO_PAIR},
        '{8'hFF, 1'b0, 1'b0, 1'b0, NO_PAIR},
        '{8'h7F, 1'b0, 1'b0, 1'b0, NO_PAIR},
        '{8'h77, 1'b0, 1'b0, 1'b1, '{16'sd32767, 16'sd32767, 1'b0}},
        '{8'hFF, 1'b0, 1'b1, 1'b1, '{16'sh8000, 16'sh8000, 1'b1}},
        '{8'h00, 1'b1, 1'b0, 1'b0, NO_PAIR},
        '{8'h80, 1'b0, 1'b0, 1'b0, NO_PAIR},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_PAIR},
        '{8'h80, 1'b0, 1'b0, 1'b0, NO_PAIR},
        '{8'h19, 1'b0, 1'b1, 1'b1, '{16'sd0, 16'sd16, 1'b1}},
        '{8'h55, 1'b1, 1'b0, 1'b0, NO_PAIR},
        '{8'hAA, 1'b0, 1'b1, 1'b0, NO_PAIR},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_PAIR},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_PAIR},
        '{8'h03, 1'b0, 1'b0, 1'b0, NO_PAIR},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_PAIR},
        '{8'h7F, 1'b0, 1'b0, 1'b0, NO_PAIR},
        '{8'h3C, 1'b1, 1'b1, 1'b0, NO_PAIR}
    };

    // Decodes one 4-bit code against the predictor state and returns the new
    // sample. The step follows the gain of the magnitude. It is cut to 16 bits
    // and then held at or above the floor.
    function automatic logic signed [15:0] decode_code(input logic [3:0] code);
        int                 mag;
        int                 acc;
        int                 scaled;
        logic signed [15:0] next_step;
        mag = int'(code[2:0]);
        acc = int'(model_sample);
        if (code[3])
            acc = acc - mag * int'(model_step);
        else
            acc = acc + mag * int'(model_step);
        if (acc > int'(SAMPLE_MAX))
            acc = int'(SAMPLE_MAX);
        else if (acc < int'(SAMPLE_MIN))
            acc = int'(SAMPLE_MIN);
        model_sample = acc[15:0];
        scaled = (STEP_GAIN[mag] * int'(model_step)) >>> 8;
        next_step = scaled[15:0];
        if (next_step < STEP_FLOOR)
            next_step = STEP_FLOOR;
        model_step = next_step;
        return model_sample;
    endfunction

    // Applies one accepted beat to the predictor. A data byte yields a pair.
    // A header byte only loads the sample or the step.
    function automatic void absorb_beat(input logic [7:0] data, input logic first,
                                        input logic last, output bit has_pair,
                                        output pair_t pair);
        has_pair = 1'b0;
        pair = NO_PAIR;
        if (first)
            hdr_pos = 0;
        if (hdr_pos < HDR_BYTES)
        begin
            case (hdr_pos[1:0])
                HDR_PRED_LO: model_sample[7:0]  = data;
                HDR_PRED_HI: model_sample[15:8] = data;
                HDR_STEP_LO: model_step[7:0]    = data;
                HDR_STEP_HI: model_step[15:8]   = data;
            endcase
            hdr_pos++;
        end
        else
        begin
            pair.lo_sample = decode_code(data[3:0]);
            pair.hi_sample = decode_code(data[7:4]);
            pair.eop = last;
            has_pair = 1'b1;
        end
        if (last)
            hdr_pos = 0;
    endfunction

    // Offers one beat, with a random gap first, and holds it until it is
    // accepted. Valid is raised without looking at stall. Only a beat that the
    // block accepts reaches the predictor.
    task automatic send_beat(input logic [7:0] data, input logic first, input logic last,
                             input bit want_typed, input pair_t want);
        bit    has_pair;
        pair_t pair;
        while (!quiet && $urandom_range(99, 0) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        packet_byte     <= data;
        first_of_packet <= first;
        last_of_packet  <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        absorb_beat(data, first, last, has_pair, pair);
        if (has_pair)
            owed_pairs.push_back(want_typed ? want : pair);
        beats_sent++;
    endtask

    // Sends one random packet. Most packets are well formed: a first flag, a
    // header, and a run of data bytes that ends with the last flag. Some are
    // cut short with no last flag. The rest are bytes with random flags.
    task automatic send_random_packet();
        logic [15:0] hdr_sample;
        logic [15:0] hdr_step;
        int          kind;
        int          step_pick;
        int          n_data;
        kind = $urandom_range(99, 0);
        if (kind >= 88)
        begin
            n_data = $urandom_range(8, 1);
            for (int i = 0; i < n_data; i++)
                send_beat(8'($urandom), $urandom_range(3, 0) == 0,
                          $urandom_range(3, 0) == 0, 1'b0, NO_PAIR);
        end
        else
        begin
            hdr_sample = 16'($urandom);
            step_pick = $urandom_range(99, 0);
            if (step_pick < 70)
                hdr_step = 16'($urandom_range(2048, 16));
            else if (step_pick < 85)
                hdr_step = 16'($urandom);
            else
                hdr_step = 16'($urandom_range(15, 0));
            n_data = ($urandom_range(9, 0) == 0) ? 1 : $urandom_range(24, 2);
            send_beat(hdr_sample[7:0],  1'b1, 1'b0, 1'b0, NO_PAIR);
            send_beat(hdr_sample[15:8], 1'b0, 1'b0, 1'b0, NO_PAIR);
            send_beat(hdr_step[7:0],    1'b0, 1'b0, 1'b0, NO_PAIR);
            send_beat(hdr_step[15:8],   1'b0, 1'b0, 1'b0, NO_PAIR);
            // A cut-short packet leaves the decoder in its data phase. The next
            // first flag has to pull it back to a header.
            for (int i = 0; i < n_data; i++)
                send_beat(8'($urandom), 1'b0, (i == n_data - 1) && (kind < 80),
                          1'b0, NO_PAIR);
        end
        packets_sent++;
    endtask

    task automatic report_field(input string field, input int want, input int got);
        errors++;
        if (errors <= 10)
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
    endtask

    // The receiver stalls at random, except in the quiet stretch.
    always @(posedge clk)
    begin
        out_stall <= !quiet && ($urandom_range(99, 0) < IDLE_PERCENT);
    end

    // Checks each output beat against the oldest owed pair.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (owed_pairs.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected output beat: %0d %0d eop %0b", $realtime,
                             sample_first, sample_second, end_of_packet);
            end
            else
            begin
                head_pair = owed_pairs.pop_front();
                pairs_checked++;
                if (sample_first !== head_pair.lo_sample)
                    report_field("sample_first", head_pair.lo_sample, sample_first);
                if (sample_second !== head_pair.hi_sample)
                    report_field("sample_second", head_pair.hi_sample, sample_second);
                if (end_of_packet !== head_pair.eop)
                    report_field("end_of_packet", head_pair.eop, end_of_packet);
            end
        end
    end

    // The watchdog counts cycles in which neither channel moves a beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $realtime, idle_cycles);
                $display("adpcm_nibble_decoder regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        hdr_pos = 0;
        model_sample = '0;
        model_step = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].data, directed_rows[i].first, directed_rows[i].last,
                      directed_rows[i].want_typed, directed_rows[i].want);

        // Random packets. One stretch in the middle runs with no idling on
        // either side.
        while (beats_sent < TARGET_BEATS)
        begin
            quiet = (beats_sent >= 900) && (beats_sent < 1300);
            send_random_packet();
        end
        quiet = 1'b0;
        in_valid <= 1'b0;

        while (owed_pairs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d input beats in %0d random packets after %0d directed rows.",
                 beats_sent, packets_sent, NUM_DIRECTED);
        $display("Checked %0d decoded pairs; %0d mismatches found.", pairs_checked, errors);
        if (errors == 0)
            $display("adpcm_nibble_decoder regression: pass");
        else
            $display("adpcm_nibble_decoder regression: fail");
        $finish;
    end

endmodule
